FILE: sv/cta_pkg.sv
`timescale 1ns / 1ps
// Shared constants and helpers for the calendar time advance unit.
// Depends on nothing; imported by calendar_time_advance_unit.
package cta_pkg;

  localparam int UPTIME_W = 63;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_DATA_W = 40;

  // Day count of the carried elapsed days; bounded by 32-bit seconds.
  localparam int DCNT_W = 16;
  // Operand, product and remainder widths of the shared constant divider.
  localparam int DVD_W  = 32;
  localparam int PROD_W = 64;
  localparam int REM_W  = 9;
  localparam int C400_W = 9;

  // Milliseconds are divided by eight with a shift, then by 125.
  localparam logic [REM_W-1:0] DIV_MS_8 = REM_W'(125);
  localparam logic [REM_W-1:0] DIV_SEC  = REM_W'(60);
  localparam logic [REM_W-1:0] DIV_HOUR = REM_W'(24);
  localparam logic [REM_W-1:0] DIV_YEAR = REM_W'(400);

  // Reciprocals: the quotient is the product shifted right, exact for 32-bit operands.
  localparam logic [DVD_W-1:0] MAGIC_MS_8 = 32'd274877907;
  localparam logic [DVD_W-1:0] MAGIC_SEC  = 32'd2290649225;
  localparam logic [DVD_W-1:0] MAGIC_HOUR = 32'd2863311531;
  localparam logic [DVD_W-1:0] MAGIC_YEAR = 32'd2748779070;
  localparam int SHIFT_MS_8 = 35;
  localparam int SHIFT_SEC  = 37;
  localparam int SHIFT_HOUR = 36;
  localparam int SHIFT_YEAR = 40;

  // Largest elapsed time whose whole seconds still fit in 32 bits.
  localparam logic [UPTIME_W-1:0] ELAPSED_MAX = 63'd4294967295999;

  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(16383);
  localparam logic [C400_W-1:0] C400_LAST = C400_W'(399);
  localparam logic [MONTH_W:0] MONTHS_PER_YEAR = (MONTH_W+1)'(12);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_YEAR      = 3'd0,
    REG_BASE_MONTH     = 3'd1,
    REG_BASE_DAY       = 3'd2,
    REG_BASE_HOUR      = 3'd3,
    REG_BASE_MINUTE    = 3'd4,
    REG_BASE_SECOND    = 3'd5,
    REG_BASE_UPTIME_MS = 3'd6
  } cfg_reg_t;

  // Days per month for a common year; codes outside 1..12 count as 30 days.
  localparam logic [DAY_W-1:0] MONTH_DAYS [16] = '{
    5'd30, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd30, 5'd30, 5'd30
  };

  // Leap year test from the year modulo 400.
  function automatic logic is_leap(input logic [C400_W-1:0] c400);
    return (c400[1:0] == 2'b00) && (c400 != C400_W'(100)) &&
           (c400 != C400_W'(200)) && (c400 != C400_W'(300));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    d = MONTH_DAYS[mo];
    if (mo == MONTH_W'(2) && leap) begin
      d = DAY_W'(29);
    end
    return d;
  endfunction

endpackage

FILE: sv/calendar_time_advance_unit.sv
`timescale 1ns / 1ps
// From an accepted request to its result: the saturate state clamps the elapsed time, then
// six constant divisions share one 32 by 32 reciprocal multiplier, each passing through a
// multiply, a remainder and a fix state; then the month carry steps through each of the
// months carried, up to roughly 1640 for 32-bit elapsed seconds, plus a saturation step when
// the year would pass its bound, and waits for the output register to be free. The next
// request is taken while the last result waits. Reset is synchronous: it clears the
// sequencer and loads the base registers. Depends on cta_pkg.
module calendar_time_advance_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cta_pkg::UPTIME_W-1:0]    cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now_uptime_ms in bits 62:0, bit 63 zero.
  input  logic [63:0]                     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_second, out_minute, out_hour, out_day, out_month, out_year.
  output logic [cta_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // clamped.
  output logic                            m_axis_tuser
);
  import cta_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SAT, ST_MUL, ST_REM, ST_FIX, ST_MONTH
  } state_t;

  typedef enum logic [2:0] {
    DV_MS_HI, DV_MS_LO, DV_SEC, DV_MIN, DV_HOUR, DV_YEAR
  } div_stage_t;

  state_t               state;
  div_stage_t           stage;
  logic [UPTIME_W-1:0]  elapsed;
  logic [DVD_W-1:0]     dvd;
  logic [DVD_W-1:0]     quo;
  logic [REM_W-1:0]     rem;
  logic [7:0]           secs_hi;
  logic [1:0]           carry;
  logic                 flag;

  logic [YEAR_W-1:0]    base_year;
  logic [MONTH_W-1:0]   base_month;
  logic [DAY_W-1:0]     base_day;
  logic [HOUR_W-1:0]    base_hour;
  logic [MIN_W-1:0]     base_minute;
  logic [SEC_W-1:0]     base_second;
  logic [UPTIME_W-1:0]  base_uptime_ms;

  logic [SEC_W-1:0]     sec_r;
  logic [MIN_W-1:0]     min_r;
  logic [HOUR_W-1:0]    hour_r;
  logic [DCNT_W-1:0]    day;
  logic [MONTH_W-1:0]   mo;
  logic [YEAR_W-1:0]    yr;
  logic [C400_W-1:0]    c400;

  logic [REM_W-1:0]     divisor;
  logic [DVD_W-1:0]     magic;
  logic [DVD_W-1:0]     quo_est;
  logic [DVD_W-1:0]     mul_a;
  logic [DVD_W-1:0]     mul_b;
  logic [PROD_W-1:0]    prod;
  logic [DVD_W-1:0]     rem_full;
  logic [REM_W-1:0]     wrap_sum;
  logic [REM_W-1:0]     wrap_two;
  logic [REM_W-1:0]     wrap_val;
  logic [1:0]           wrap_carry;
  logic                 elapsed_sat;
  logic [UPTIME_W-1:0]  elapsed_lim;
  logic [UPTIME_W-1:0]  now_ms;
  logic                 in_accept;
  logic                 out_free;
  logic                 month_done;
  logic                 out_load;
  logic [DAY_W-1:0]     dim;
  logic [MONTH_W:0]     mo_inc;

  assign now_ms        = s_axis_tdata[UPTIME_W-1:0];
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    unique case (stage)
      DV_MS_HI, DV_MS_LO: begin
        divisor = DIV_MS_8;
        magic   = MAGIC_MS_8;
        quo_est = DVD_W'(prod[PROD_W-1:SHIFT_MS_8]);
      end
      DV_SEC, DV_MIN: begin
        divisor = DIV_SEC;
        magic   = MAGIC_SEC;
        quo_est = DVD_W'(prod[PROD_W-1:SHIFT_SEC]);
      end
      DV_HOUR: begin
        divisor = DIV_HOUR;
        magic   = MAGIC_HOUR;
        quo_est = DVD_W'(prod[PROD_W-1:SHIFT_HOUR]);
      end
      DV_YEAR: begin
        divisor = DIV_YEAR;
        magic   = MAGIC_YEAR;
        quo_est = DVD_W'(prod[PROD_W-1:SHIFT_YEAR]);
      end
      default: begin
        divisor = DIV_MS_8;
        magic   = MAGIC_MS_8;
        quo_est = DVD_W'(prod[PROD_W-1:SHIFT_MS_8]);
      end
    endcase
  end

  // The multiplier forms the quotient estimate first, then quotient times divisor.
  assign mul_a    = (state == ST_REM) ? quo : dvd;
  assign mul_b    = (state == ST_REM) ? DVD_W'(divisor) : magic;
  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rem_full = dvd - prod[DVD_W-1:0];

  always_comb begin
    unique case (stage)
      DV_SEC:  wrap_sum = rem + REM_W'(base_second);
      DV_MIN:  wrap_sum = rem + REM_W'(base_minute) + REM_W'(carry);
      DV_HOUR: wrap_sum = rem + REM_W'(base_hour) + REM_W'(carry);
      default: wrap_sum = rem;
    endcase
  end

  assign wrap_two = {divisor[REM_W-2:0], 1'b0};

  always_comb begin
    priority if (wrap_sum >= wrap_two) begin
      wrap_val   = wrap_sum - wrap_two;
      wrap_carry = 2'd2;
    end else if (wrap_sum >= divisor) begin
      wrap_val   = wrap_sum - divisor;
      wrap_carry = 2'd1;
    end else begin
      wrap_val   = wrap_sum;
      wrap_carry = 2'd0;
    end
  end

  assign elapsed_sat = elapsed > ELAPSED_MAX;
  assign elapsed_lim = elapsed_sat ? ELAPSED_MAX : elapsed;

  assign dim        = month_days(mo, is_leap(c400));
  assign mo_inc     = {1'b0, mo} + (MONTH_W+1)'(1);
  assign month_done = day <= DCNT_W'(dim);
  assign out_load   = (state == ST_MONTH) && month_done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      stage          <= DV_MS_HI;
      flag           <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      base_year      <= YEAR_W'(2000);
      base_month     <= MONTH_W'(1);
      base_day       <= DAY_W'(1);
      base_hour      <= '0;
      base_minute    <= '0;
      base_second    <= '0;
      base_uptime_ms <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE_YEAR:      base_year      <= cfg_data[YEAR_W-1:0];
          REG_BASE_MONTH:     base_month     <= cfg_data[MONTH_W-1:0];
          REG_BASE_DAY:       base_day       <= cfg_data[DAY_W-1:0];
          REG_BASE_HOUR:      base_hour      <= cfg_data[HOUR_W-1:0];
          REG_BASE_MINUTE:    base_minute    <= cfg_data[MIN_W-1:0];
          REG_BASE_SECOND:    base_second    <= cfg_data[SEC_W-1:0];
          REG_BASE_UPTIME_MS: base_uptime_ms <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (now_ms < base_uptime_ms) begin
              flag    <= 1'b1;
              elapsed <= '0;
            end else begin
              flag    <= 1'b0;
              elapsed <= now_ms - base_uptime_ms;
            end
            stage <= DV_MS_HI;
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (elapsed_sat) begin
            flag <= 1'b1;
          end
          elapsed <= elapsed_lim;
          // Elapsed milliseconds over eight, upper digit from bit 24 up.
          dvd     <= DVD_W'(elapsed_lim[41:27]);
          state   <= ST_MUL;
        end
        ST_MUL: begin
          quo   <= quo_est;
          state <= ST_REM;
        end
        ST_REM: begin
          rem   <= rem_full[REM_W-1:0];
          state <= ST_FIX;
        end
        ST_FIX: begin
          state <= ST_MUL;
          unique case (stage)
            DV_MS_HI: begin
              secs_hi <= quo[7:0];
              dvd     <= {1'b0, rem[6:0], elapsed[26:3]};
              stage   <= DV_MS_LO;
            end
            DV_MS_LO: begin
              dvd   <= {secs_hi, quo[23:0]};
              stage <= DV_SEC;
            end
            DV_SEC: begin
              sec_r <= wrap_val[SEC_W-1:0];
              carry <= wrap_carry;
              dvd   <= quo;
              stage <= DV_MIN;
            end
            DV_MIN: begin
              min_r <= wrap_val[MIN_W-1:0];
              carry <= wrap_carry;
              dvd   <= quo;
              stage <= DV_HOUR;
            end
            DV_HOUR: begin
              hour_r <= wrap_val[HOUR_W-1:0];
              day    <= quo[DCNT_W-1:0] + DCNT_W'(base_day) + DCNT_W'(wrap_carry);
              dvd    <= DVD_W'(base_year);
              stage  <= DV_YEAR;
            end
            DV_YEAR: begin
              c400  <= rem[C400_W-1:0];
              mo    <= base_month;
              yr    <= base_year;
              state <= ST_MONTH;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_MONTH: begin
          if (month_done) begin
            if (out_free) begin
              m_axis_tdata <= {yr, mo, day[DAY_W-1:0], hour_r, min_r, sec_r};
              m_axis_tuser <= flag;
              state        <= ST_IDLE;
            end
          end else if (mo_inc > MONTHS_PER_YEAR && yr == YEAR_MAX) begin
            // The year would pass its upper bound: pin to the last second.
            mo     <= MONTH_W'(12);
            day    <= DCNT_W'(31);
            hour_r <= HOUR_W'(23);
            min_r  <= MIN_W'(59);
            sec_r  <= SEC_W'(59);
            flag   <= 1'b1;
          end else if (mo_inc > MONTHS_PER_YEAR) begin
            day  <= day - DCNT_W'(dim);
            mo   <= MONTH_W'(1);
            yr   <= yr + YEAR_W'(1);
            c400 <= (c400 == C400_LAST) ? '0 : c400 + C400_W'(1);
          end else begin
            day <= day - DCNT_W'(dim);
            mo  <= mo_inc[MONTH_W-1:0];
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/calendar_time_advance_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for calendar_time_advance_unit: directed table, then random requests
// under three handshake pacing phases, each checked against its table result or a calendar predictor.
// Depends on cta_pkg and calendar_time_advance_unit.
module calendar_time_advance_unit_tb;
  import cta_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 7;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES    = 2100;
  localparam int ITEMS_PER_BLOCK = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam logic [62:0] UPTIME_MAX = {63{1'b1}};
  localparam logic [63:0] SAT_EDGE_MS = 64'd4294967296000;
  localparam logic [62:0] DAY_MS = 63'd86400000;

  typedef struct packed {
    logic              clamped;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } calendar_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] index;
    logic [62:0]          value;
    bit                   typed;
    calendar_t            result;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [UPTIME_W-1:0]   cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  logic [YEAR_W-1:0]  epoch_year = 14'd2000;
  logic [MONTH_W-1:0] epoch_month = 4'd1;
  logic [DAY_W-1:0]   epoch_day = 5'd1;
  logic [HOUR_W-1:0]  epoch_hour = '0;
  logic [MIN_W-1:0]   epoch_minute = '0;
  logic [SEC_W-1:0]   epoch_second = '0;
  logic [62:0]        epoch_uptime = '0;

  calendar_t expected_calendar[$];
  dir_row_t  dir_rows[$];
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  calendar_time_advance_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic calendar_t calendar_of(input int y, input int mo, input int d, input int h,
                                            input int mi, input int s, input bit c);
    calendar_t r;
    r.clamped = c;
    r.year = YEAR_W'(y);
    r.month = MONTH_W'(mo);
    r.day = DAY_W'(d);
    r.hour = HOUR_W'(h);
    r.minute = MIN_W'(mi);
    r.second = SEC_W'(s);
    return r;
  endfunction

  function automatic longint unsigned month_length(input longint unsigned y,
                                                   input longint unsigned mo);
    case (mo)
      1, 3, 5, 7, 8, 10, 12: return 31;
      2: return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
      default: return 30;
    endcase
  endfunction

  function automatic calendar_t advance_calendar(input logic [62:0] now);
    longint unsigned secs, s, mi, h, d, mo, y, mlen;
    logic clamp;
    bit done;
    calendar_t r;
    secs = 0;
    clamp = 1'b0;
    done = 1'b0;
    if (now < epoch_uptime) begin
      clamp = 1'b1;
    end else begin
      secs = (64'(now) - 64'(epoch_uptime)) / 1000;
      if (secs > 64'hFFFF_FFFF) begin
        secs = 64'hFFFF_FFFF;
        clamp = 1'b1;
      end
    end
    s = epoch_second + secs;
    mi = epoch_minute + s / 60;
    s = s % 60;
    h = epoch_hour + mi / 60;
    mi = mi % 60;
    d = epoch_day + h / 24;
    h = h % 24;
    mo = epoch_month;
    y = epoch_year;
    while (!done) begin
      mlen = month_length(y, mo);
      if (d <= mlen) begin
        done = 1'b1;
      end else begin
        d = d - mlen;
        mo = mo + 1;
        if (mo > 12) begin
          mo = 1;
          if (y >= YEAR_MAX) begin
            // Carry out of the last representable year pins the date at its end.
            y = YEAR_MAX;
            mo = 12;
            d = 31;
            h = 23;
            mi = 59;
            s = 59;
            clamp = 1'b1;
            done = 1'b1;
          end else begin
            y = y + 1;
          end
        end
      end
    end
    r.clamped = clamp;
    r.year = YEAR_W'(y);
    r.month = MONTH_W'(mo);
    r.day = DAY_W'(d);
    r.hour = HOUR_W'(h);
    r.minute = MIN_W'(mi);
    r.second = SEC_W'(s);
    return r;
  endfunction

  task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [62:0] val);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.index = idx;
    row.value = val;
    row.typed = 1'b0;
    row.result = '0;
    dir_rows.push_back(row);
  endtask

  task automatic row_item(input logic [62:0] now, input bit typed, input calendar_t res);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.index = '0;
    row.value = now;
    row.typed = typed;
    row.result = res;
    dir_rows.push_back(row);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (expected_calendar.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [62:0] val,
                           input bit noisy);
    logic [62:0] mask, data;
    case (idx)
      REG_BASE_YEAR:      mask = 63'({YEAR_W{1'b1}});
      REG_BASE_MONTH:     mask = 63'({MONTH_W{1'b1}});
      REG_BASE_DAY:       mask = 63'({DAY_W{1'b1}});
      REG_BASE_HOUR:      mask = 63'({HOUR_W{1'b1}});
      REG_BASE_MINUTE:    mask = 63'({MIN_W{1'b1}});
      REG_BASE_SECOND:    mask = 63'({SEC_W{1'b1}});
      REG_BASE_UPTIME_MS: mask = UPTIME_MAX;
      default:            mask = '0;
    endcase
    data = noisy ? ((rand63() & ~mask) | (val & mask)) : val;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_BASE_YEAR:      epoch_year = data[YEAR_W-1:0];
      REG_BASE_MONTH:     epoch_month = data[MONTH_W-1:0];
      REG_BASE_DAY:       epoch_day = data[DAY_W-1:0];
      REG_BASE_HOUR:      epoch_hour = data[HOUR_W-1:0];
      REG_BASE_MINUTE:    epoch_minute = data[MIN_W-1:0];
      REG_BASE_SECOND:    epoch_second = data[SEC_W-1:0];
      REG_BASE_UPTIME_MS: epoch_uptime = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_uptime(input logic [62:0] now, input bit typed, input calendar_t res);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {1'b0, now};
    do @(posedge clk); while (!s_axis_tready);
    expected_calendar.push_back(typed ? res : advance_calendar(now));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic randomize_base();
    int v;
    v = ($urandom_range(0, 99) < 70) ? $urandom_range(1583, 9999) :
        ($urandom_range(0, 1) == 0) ? $urandom_range(16200, 16383) : $urandom_range(0, 16383);
    write_reg(REG_BASE_YEAR, 63'(v), $urandom_range(0, 3) == 0);
    v = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    write_reg(REG_BASE_MONTH, 63'(v), $urandom_range(0, 3) == 0);
    v = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 28) : $urandom_range(0, 31);
    write_reg(REG_BASE_DAY, 63'(v), $urandom_range(0, 3) == 0);
    v = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 23) : $urandom_range(0, 31);
    write_reg(REG_BASE_HOUR, 63'(v), $urandom_range(0, 3) == 0);
    v = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(0, 63);
    write_reg(REG_BASE_MINUTE, 63'(v), $urandom_range(0, 3) == 0);
    v = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(0, 63);
    write_reg(REG_BASE_SECOND, 63'(v), $urandom_range(0, 3) == 0);
    v = $urandom_range(0, 99);
    if (v < 50) begin
      write_reg(REG_BASE_UPTIME_MS, 63'(64'($urandom) * 64'($urandom_range(1, 1000))), 1'b0);
    end else if (v < 80) begin
      write_reg(REG_BASE_UPTIME_MS, '0, 1'b0);
    end else begin
      write_reg(REG_BASE_UPTIME_MS, rand63(), 1'b0);
    end
    write_reg(CFG_UNMAPPED, rand63(), 1'b0);
  endtask

  function automatic logic [62:0] random_uptime();
    logic [63:0] elapsed;
    logic [62:0] now;
    int pick;
    pick = $urandom_range(0, 99);
    elapsed = '0;
    if (pick < 40) begin
      elapsed = 64'($urandom_range(0, 99999999));
    end else if (pick < 70) begin
      elapsed = 64'($urandom) * 64'($urandom_range(1, 40));
    end else if (pick < 80) begin
      elapsed = SAT_EDGE_MS - 64'd1500 + 64'($urandom_range(0, 3000));
    end
    if (pick < 80) begin
      now = 63'(64'(epoch_uptime) + elapsed);
    end else if (pick < 90) begin
      now = epoch_uptime - 63'(1) - 63'($urandom_range(0, 999));
    end else begin
      now = rand63();
    end
    return now;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      m_axis_tready = ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    calendar_t want, got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        results_seen++;
        if (expected_calendar.size() == 0) begin
          $display("%0t: result with no pending request: %0d-%0d-%0d %0d:%0d:%0d clamped=%0b",
                   $time, got.year, got.month, got.day, got.hour, got.minute, got.second,
                   got.clamped);
          errors++;
        end else begin
          want = expected_calendar.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %0d-%0d-%0d %0d:%0d:%0d clamped=%0b, actual %0d-%0d-%0d %0d:%0d:%0d clamped=%0b",
                     $time, want.year, want.month, want.day, want.hour, want.minute,
                     want.second, want.clamped, got.year, got.month, got.day, got.hour,
                     got.minute, got.second, got.clamped);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no request moved for %0d cycles", $time, idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t row;
    int phase, blk;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Reset base is 2000-01-01 00:00:00 with a reference uptime of zero.
    row_item(63'd0, 1'b1, calendar_of(2000, 1, 1, 0, 0, 0, 1'b0));
    row_item(63'd999, 1'b1, calendar_of(2000, 1, 1, 0, 0, 0, 1'b0));
    row_item(63'd1000, 1'b1, calendar_of(2000, 1, 1, 0, 0, 1, 1'b0));
    row_item(DAY_MS, 1'b1, calendar_of(2000, 1, 2, 0, 0, 0, 1'b0));
    row_item(63'd59999, 1'b0, '0);
    row_item(DAY_MS * 59, 1'b0, '0);
    row_item(DAY_MS * 60, 1'b0, '0);
    row_item(63'(SAT_EDGE_MS - 64'd1), 1'b0, '0);
    row_item(63'(SAT_EDGE_MS), 1'b0, '0);
    row_item(UPTIME_MAX, 1'b0, '0);
    // Uptime below the reference clamps the elapsed time to zero.
    row_cfg(REG_BASE_UPTIME_MS, 63'd5000000);
    row_item(63'd4999999, 1'b1, calendar_of(2000, 1, 1, 0, 0, 0, 1'b1));
    row_item(63'd5000000, 1'b1, calendar_of(2000, 1, 1, 0, 0, 0, 1'b0));
    row_item(63'd0, 1'b1, calendar_of(2000, 1, 1, 0, 0, 0, 1'b1));
    // Any carry out of the last year saturates the whole date.
    row_cfg(REG_BASE_YEAR, 63'd16383);
    row_cfg(REG_BASE_MONTH, 63'd12);
    row_cfg(REG_BASE_DAY, 63'd31);
    row_cfg(REG_BASE_HOUR, 63'd23);
    row_cfg(REG_BASE_MINUTE, 63'd59);
    row_cfg(REG_BASE_SECOND, 63'd59);
    row_cfg(REG_BASE_UPTIME_MS, 63'd0);
    row_item(63'd0, 1'b1, calendar_of(16383, 12, 31, 23, 59, 59, 1'b0));
    row_item(63'd1000, 1'b1, calendar_of(16383, 12, 31, 23, 59, 59, 1'b1));
    row_item(UPTIME_MAX, 1'b1, calendar_of(16383, 12, 31, 23, 59, 59, 1'b1));
    // Out-of-range base fields, with a write to the unmapped index in between.
    row_cfg(REG_BASE_YEAR, 63'd0);
    row_cfg(REG_BASE_MONTH, 63'd0);
    row_cfg(REG_BASE_DAY, 63'd0);
    row_cfg(REG_BASE_HOUR, 63'd31);
    row_cfg(REG_BASE_MINUTE, 63'd63);
    row_cfg(REG_BASE_SECOND, 63'd63);
    row_cfg(CFG_UNMAPPED, UPTIME_MAX);
    row_item(63'd0, 1'b0, '0);
    row_item(DAY_MS * 30, 1'b0, '0);
    row_cfg(REG_BASE_YEAR, 63'd9999);
    row_cfg(REG_BASE_MONTH, 63'd15);
    row_cfg(REG_BASE_DAY, 63'd31);
    row_cfg(REG_BASE_HOUR, 63'd0);
    row_cfg(REG_BASE_MINUTE, 63'd0);
    row_cfg(REG_BASE_SECOND, 63'd0);
    row_item(63'd0, 1'b0, '0);
    row_item(DAY_MS, 1'b0, '0);
    // Century years: 1900 is a common year, 2400 is a leap year.
    row_cfg(REG_BASE_YEAR, 63'd1900);
    row_cfg(REG_BASE_MONTH, 63'd2);
    row_cfg(REG_BASE_DAY, 63'd28);
    row_item(DAY_MS, 1'b0, '0);
    row_cfg(REG_BASE_YEAR, 63'd2400);
    row_item(DAY_MS, 1'b0, '0);

    src_idle_pct = 26;
    sink_idle_pct = 79;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.index, row.value, 1'b0);
      end else begin
        send_uptime(row.value, row.typed, row.result);
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 79 : 0;
      sink_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 26 : 0;
      for (blk = 0; blk < 2; blk++) begin
        wait_idle();
        randomize_base();
        repeat (ITEMS_PER_BLOCK) send_uptime(random_uptime(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d uptime requests, checked %0d results, made %0d register writes.",
             requests_sent, results_seen, reg_writes);
    $display("Covered reset defaults, clamping, saturation, odd base fields and three pacings.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
